// File: design/chained_free_block_stack_macros.svh
// Assertion macros shared by the free block stack RTL.
// No dependencies; included by the files that carry checks.
`ifndef CHAINED_FREE_BLOCK_STACK_MACROS_SVH
`define CHAINED_FREE_BLOCK_STACK_MACROS_SVH

// condition must hold at every clock edge out of reset
`define CFBS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("free block stack check failed");

// consequent must hold in the same cycle as the antecedent
`define CFBS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("free block stack check failed");

`endif

// File: design/cfbs_pkg.sv
// Shared types, constants and helpers of the free block stack.
// No dependencies.
package cfbs_pkg;

    localparam int CAPACITY   = 32;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int BLK_W      = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register indexes (paddr[2])
    localparam logic REG_INODE_BLOCKS  = 1'b0;
    localparam logic REG_VOLUME_BLOCKS = 1'b1;

    // request kinds
    localparam logic [1:0] KIND_ALLOC   = 2'd0;
    localparam logic [1:0] KIND_FREE    = 2'd1;
    localparam logic [1:0] KIND_REFILL  = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    // result kinds
    localparam logic RK_REPLY = 1'b0;
    localparam logic RK_SPILL = 1'b1;

    // reply status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_REFILL    = 3'd1;
    localparam logic [2:0] ST_SPILLED   = 3'd2;
    localparam logic [2:0] ST_NO_SPACE  = 3'd3;
    localparam logic [2:0] ST_BAD_BLOCK = 3'd4;
    localparam logic [2:0] ST_BUSY      = 3'd5;
    localparam logic [2:0] ST_BAD_COUNT = 3'd6;

    typedef struct packed {
        logic [BLK_W-1:0] inode_blocks;
        logic [BLK_W-1:0] volume_blocks;
    } cfg_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BLK_W-1:0]  wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    // valid blocks lie in [inode_blocks + 2, volume_blocks); sum kept unwrapped
    function automatic logic is_bad(input logic [BLK_W-1:0] bn, input cfg_t cfg);
        logic [BLK_W:0] low_lim;
        low_lim = {1'b0, cfg.inode_blocks} + (BLK_W + 1)'(2);
        return ({1'b0, bn} < low_lim) || (bn >= cfg.volume_blocks);
    endfunction

endpackage

// File: design/cfbs_ram.sv
// Generic single-clock RAM, one write and one read port, registered read.
// No dependencies.
module cfbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/cfbs_regs.sv
// APB-style configuration registers of the free block stack.
// Depends on cfbs_pkg.
module cfbs_regs
    import cfbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [BLK_W-1:0] inode_blocks_reg;
    logic [BLK_W-1:0] volume_blocks_reg;
    logic             wr_en;
    logic             reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inode_blocks_reg  <= '0;
            volume_blocks_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_INODE_BLOCKS:  inode_blocks_reg  <= pwdata[BLK_W-1:0];
                REG_VOLUME_BLOCKS: volume_blocks_reg <= pwdata[BLK_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_INODE_BLOCKS:  prdata = {(APB_DATA_W - BLK_W)'(0), inode_blocks_reg};
            REG_VOLUME_BLOCKS: prdata = {(APB_DATA_W - BLK_W)'(0), volume_blocks_reg};
            default:           prdata = '0;
        endcase
    end

    assign cfg.inode_blocks  = inode_blocks_reg;
    assign cfg.volume_blocks = volume_blocks_reg;

endmodule

// File: design/cfbs_ctrl.sv
// Sequencer of the free block stack: decodes words, drives the stack memory
// and holds the result register. Depends on cfbs_pkg and the macro header.
`include "chained_free_block_stack_macros.svh"

module cfbs_ctrl
    import cfbs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       kind,
    input  logic [BLK_W-1:0] block_number,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             result_kind,
    output logic [2:0]       status,
    output logic [BLK_W-1:0] value,
    output logic             last,
    output ram_req_t         ram_req,
    input  logic [BLK_W-1:0] ram_rdata
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_REPLY     = 3'd1;
    localparam logic [2:0] S_ALLOC     = 3'd2;
    localparam logic [2:0] S_ALLOC_CHK = 3'd3;
    localparam logic [2:0] S_PUSH      = 3'd4;
    localparam logic [2:0] S_SPILL_HDR = 3'd5;
    localparam logic [2:0] S_SPILL_RD  = 3'd6;
    localparam logic [2:0] S_SPILL_OUT = 3'd7;

    logic [2:0]        state_reg,      state_next;
    logic [CNT_W-1:0]  free_count_reg, free_count_next;
    logic [CNT_W-1:0]  refill_rem_reg, refill_rem_next;
    logic [CNT_W-1:0]  refill_idx_reg, refill_idx_next;
    logic              expecting_reg,  expecting_next;
    logic [ADDR_W-1:0] spill_idx_reg,  spill_idx_next;
    logic [BLK_W-1:0]  word_reg,       word_next;
    logic [2:0]        rep_status_reg, rep_status_next;
    logic [BLK_W-1:0]  rep_value_reg,  rep_value_next;

    logic              out_valid_reg,  out_valid_next;
    logic              out_kind_reg,   out_kind_next;
    logic [2:0]        out_status_reg, out_status_next;
    logic [BLK_W-1:0]  out_value_reg,  out_value_next;
    logic              out_last_reg,   out_last_next;

    logic              in_accept;
    logic              slot_free;
    logic              pending;
    logic [CNT_W-1:0]  count_dec;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign pending   = expecting_reg || (refill_rem_reg != '0);
    assign count_dec = free_count_reg - CNT_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        free_count_next = free_count_reg;
        refill_rem_next = refill_rem_reg;
        refill_idx_next = refill_idx_reg;
        expecting_next  = expecting_reg;
        spill_idx_next  = spill_idx_reg;
        word_next       = word_reg;
        rep_status_next = rep_status_reg;
        rep_value_next  = rep_value_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_kind_next   = out_kind_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        ram_req         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    word_next  = block_number;
                    state_next = S_REPLY;
                    case (kind)
                        KIND_REFILL:
                        begin
                            rep_value_next = block_number;
                            if (expecting_reg)
                            begin
                                expecting_next  = 1'b0;
                                refill_idx_next = '0;
                                if (block_number > BLK_W'(CAPACITY))
                                begin
                                    free_count_next = '0;
                                    refill_rem_next = '0;
                                    rep_status_next = ST_BAD_COUNT;
                                end
                                else
                                begin
                                    free_count_next = block_number[CNT_W-1:0];
                                    refill_rem_next = block_number[CNT_W-1:0];
                                    rep_status_next = ST_OK;
                                end
                            end
                            else if (refill_rem_reg != '0)
                            begin
                                // stack is filled from the bottom
                                if (refill_idx_reg < CNT_W'(CAPACITY))
                                begin
                                    ram_req.we    = 1'b1;
                                    ram_req.waddr = refill_idx_reg[ADDR_W-1:0];
                                    ram_req.wdata = block_number;
                                end
                                refill_idx_next = refill_idx_reg + CNT_W'(1);
                                refill_rem_next = refill_rem_reg - CNT_W'(1);
                                rep_status_next = ST_OK;
                            end
                            else
                            begin
                                rep_status_next = ST_BAD_COUNT;
                            end
                        end
                        KIND_ALLOC, KIND_FREE:
                        begin
                            if (pending)
                            begin
                                rep_status_next = ST_BUSY;
                                rep_value_next  = '0;
                            end
                            else if (kind == KIND_ALLOC)
                            begin
                                state_next = S_ALLOC;
                            end
                            else if (is_bad(block_number, cfg))
                            begin
                                rep_status_next = ST_BAD_BLOCK;
                                rep_value_next  = block_number;
                            end
                            else if (free_count_reg == '0)
                            begin
                                // empty stack: lay down the end mark first
                                ram_req.we      = 1'b1;
                                ram_req.waddr   = '0;
                                ram_req.wdata   = '0;
                                free_count_next = CNT_W'(1);
                                state_next      = S_PUSH;
                            end
                            else if (free_count_reg >= CNT_W'(CAPACITY))
                            begin
                                state_next = S_SPILL_HDR;
                            end
                            else
                            begin
                                ram_req.we      = 1'b1;
                                ram_req.waddr   = free_count_reg[ADDR_W-1:0];
                                ram_req.wdata   = block_number;
                                free_count_next = free_count_reg + CNT_W'(1);
                                rep_status_next = ST_OK;
                                rep_value_next  = block_number;
                            end
                        end
                        default:
                        begin
                            rep_status_next = ST_BAD_BLOCK;
                            rep_value_next  = block_number;
                        end
                    endcase
                end
            end
            S_PUSH:
            begin
                ram_req.we      = 1'b1;
                ram_req.waddr   = free_count_reg[ADDR_W-1:0];
                ram_req.wdata   = word_reg;
                free_count_next = free_count_reg + CNT_W'(1);
                rep_status_next = ST_OK;
                rep_value_next  = word_reg;
                state_next      = S_REPLY;
            end
            S_ALLOC:
            begin
                if ((free_count_reg == '0) || (free_count_reg > CNT_W'(CAPACITY)))
                begin
                    free_count_next = '0;
                    rep_status_next = ST_NO_SPACE;
                    rep_value_next  = '0;
                    state_next      = S_REPLY;
                end
                else
                begin
                    free_count_next = count_dec;
                    ram_req.re      = 1'b1;
                    ram_req.raddr   = count_dec[ADDR_W-1:0];
                    state_next      = S_ALLOC_CHK;
                end
            end
            S_ALLOC_CHK:
            begin
                if (ram_rdata == '0)
                begin
                    free_count_next = '0;
                    rep_status_next = ST_NO_SPACE;
                    rep_value_next  = '0;
                    state_next      = S_REPLY;
                end
                else if (is_bad(ram_rdata, cfg))
                begin
                    state_next = S_ALLOC;
                end
                else
                begin
                    rep_value_next = ram_rdata;
                    if (free_count_reg == '0)
                    begin
                        expecting_next  = 1'b1;
                        rep_status_next = ST_REFILL;
                    end
                    else
                    begin
                        rep_status_next = ST_OK;
                    end
                    state_next = S_REPLY;
                end
            end
            S_SPILL_HDR:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = RK_SPILL;
                    out_status_next = ST_OK;
                    out_value_next  = BLK_W'(CAPACITY);
                    out_last_next   = 1'b0;
                    spill_idx_next  = '0;
                    state_next      = S_SPILL_RD;
                end
            end
            S_SPILL_RD:
            begin
                ram_req.re    = 1'b1;
                ram_req.raddr = spill_idx_reg;
                state_next    = S_SPILL_OUT;
            end
            S_SPILL_OUT:
            begin
                // read data holds until the next read, so a stall just waits
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = RK_SPILL;
                    out_status_next = ST_OK;
                    out_value_next  = ram_rdata;
                    out_last_next   = 1'b0;
                    if (spill_idx_reg == ADDR_W'(CAPACITY - 1))
                    begin
                        ram_req.we      = 1'b1;
                        ram_req.waddr   = '0;
                        ram_req.wdata   = word_reg;
                        free_count_next = CNT_W'(1);
                        rep_status_next = ST_SPILLED;
                        rep_value_next  = word_reg;
                        state_next      = S_REPLY;
                    end
                    else
                    begin
                        spill_idx_next = spill_idx_reg + ADDR_W'(1);
                        state_next     = S_SPILL_RD;
                    end
                end
            end
            S_REPLY:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = RK_REPLY;
                    out_status_next = rep_status_reg;
                    out_value_next  = rep_value_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            free_count_reg <= '0;
            refill_rem_reg <= '0;
            refill_idx_reg <= '0;
            expecting_reg  <= 1'b0;
            spill_idx_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_count_reg <= free_count_next;
            refill_rem_reg <= refill_rem_next;
            refill_idx_reg <= refill_idx_next;
            expecting_reg  <= expecting_next;
            spill_idx_reg  <= spill_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg       <= word_next;
        rep_status_reg <= rep_status_next;
        rep_value_reg  <= rep_value_next;
        out_kind_reg   <= out_kind_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = out_kind_reg;
    assign status      = out_status_reg;
    assign value       = out_value_reg;
    assign last        = out_last_reg;

    `CFBS_ASSERT_ALWAYS(a_count_in_range, clk, rst_n, free_count_reg <= CNT_W'(CAPACITY))
    `CFBS_ASSERT_IMPLIES(a_one_refill_phase, clk, rst_n, expecting_reg, refill_rem_reg == '0)
    `CFBS_ASSERT_ALWAYS(a_no_read_on_write, clk, rst_n, !(ram_req.we && ram_req.re))
    `CFBS_ASSERT_IMPLIES(a_non_last_is_spill, clk, rst_n, out_valid_reg && !out_last_reg,
                         out_kind_reg == RK_SPILL)

endmodule

// File: design/chained_free_block_stack.sv
// Free block stack with chained overflow lists. An accepted word moves to the
// reply state, which loads its result into the output register; a free onto
// an empty stack lays down the end mark and passes the push state first. An
// allocate passes the read and check states for each entry popped from the
// single stack memory, whose read data is registered, and out-of-range entries
// are skipped the same way. A free on a full stack spills the count and all
// CAPACITY entries through the read and output states, waiting while the
// output stalls, before its reply. One word is in work at a time; in_stall is
// high until its final result is in the output register. The stack memory
// needs no clearing after reset.
// Depends on cfbs_pkg, cfbs_regs, cfbs_ctrl and cfbs_ram.
module chained_free_block_stack
    import cfbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            kind,
    input  logic [BLK_W-1:0]      block_number,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  result_kind,
    output logic [2:0]            status,
    output logic [BLK_W-1:0]      value,
    output logic                  last
);

    cfg_t             cfg;
    ram_req_t         ram_req;
    logic [BLK_W-1:0] ram_rdata;

    cfbs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cfbs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .block_number (block_number),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .status       (status),
        .value        (value),
        .last         (last),
        .ram_req      (ram_req),
        .ram_rdata    (ram_rdata)
    );

    cfbs_ram #(
        .WIDTH (BLK_W),
        .DEPTH (CAPACITY)
    ) u_stack (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

endmodule

// File: sim/chained_free_block_stack_tb.sv
// Self-checking testbench for the chained free block stack: drives words and
// register writes, predicts every reply and spill word, and checks them in order.
// Depends on cfbs_pkg and the chained_free_block_stack RTL.
module chained_free_block_stack_tb
    import cfbs_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             rkind;
        logic [2:0]       status;
        logic [BLK_W-1:0] value;
        logic             last;
    } stack_result_t;

    // Tracks the free stack as the block should hold it and queues the
    // results each accepted word must produce.
    class free_stack_tracker;
        logic [BLK_W-1:0] inode_blocks;
        logic [BLK_W-1:0] volume_blocks;
        logic [BLK_W-1:0] stack_mem [CAPACITY];
        int unsigned      depth;
        int unsigned      refill_left;
        int unsigned      refill_pos;
        bit               want_count;
        bit               spilled;
        int unsigned      errors;
        stack_result_t    due [$];

        function new();
            inode_blocks  = '0;
            volume_blocks = '0;
            foreach (stack_mem[i])
                stack_mem[i] = '0;
            depth       = 0;
            refill_left = 0;
            refill_pos  = 0;
            want_count  = 1'b0;
            spilled     = 1'b0;
            errors      = 0;
        endfunction

        function void set_reg(logic idx, logic [BLK_W-1:0] v);
            if (idx == REG_INODE_BLOCKS)
                inode_blocks = v;
            else
                volume_blocks = v;
        endfunction

        function bit out_of_range(logic [BLK_W-1:0] bn);
            return (int'(bn) < int'(inode_blocks) + 2) || (bn >= volume_blocks);
        endfunction

        function bit busy();
            return want_count || (refill_left != 0);
        endfunction

        function void due_push(logic rk, logic [2:0] st, logic [BLK_W-1:0] v, logic lst);
            stack_result_t r;
            r.rkind  = rk;
            r.status = st;
            r.value  = v;
            r.last   = lst;
            due.push_back(r);
        endfunction

        function void take_word(logic [1:0] k, logic [BLK_W-1:0] w);
            logic [BLK_W-1:0] bno;
            if (k == KIND_REFILL)
            begin
                if (want_count)
                begin
                    want_count = 1'b0;
                    refill_pos = 0;
                    if (int'(w) > CAPACITY)
                    begin
                        depth       = 0;
                        refill_left = 0;
                        due_push(RK_REPLY, ST_BAD_COUNT, w, 1'b1);
                    end
                    else
                    begin
                        depth       = 32'(w);
                        refill_left = 32'(w);
                        due_push(RK_REPLY, ST_OK, w, 1'b1);
                    end
                end
                else if (refill_left != 0)
                begin
                    if (refill_pos < CAPACITY)
                        stack_mem[refill_pos] = w;
                    refill_pos++;
                    refill_left--;
                    due_push(RK_REPLY, ST_OK, w, 1'b1);
                end
                else
                begin
                    due_push(RK_REPLY, ST_BAD_COUNT, w, 1'b1);
                end
            end
            else if (k == KIND_UNKNOWN)
            begin
                due_push(RK_REPLY, ST_BAD_BLOCK, w, 1'b1);
            end
            else if (busy())
            begin
                due_push(RK_REPLY, ST_BUSY, '0, 1'b1);
            end
            else if (k == KIND_ALLOC)
            begin
                // out-of-range entries are dropped silently; end mark stops the pop
                forever
                begin
                    if (depth == 0 || depth > CAPACITY)
                    begin
                        depth = 0;
                        due_push(RK_REPLY, ST_NO_SPACE, '0, 1'b1);
                        return;
                    end
                    depth--;
                    bno = stack_mem[depth];
                    if (bno == '0)
                    begin
                        depth = 0;
                        due_push(RK_REPLY, ST_NO_SPACE, '0, 1'b1);
                        return;
                    end
                    if (!out_of_range(bno))
                        break;
                end
                if (depth == 0)
                begin
                    want_count = 1'b1;
                    due_push(RK_REPLY, ST_REFILL, bno, 1'b1);
                end
                else
                begin
                    due_push(RK_REPLY, ST_OK, bno, 1'b1);
                end
            end
            else if (out_of_range(w))
            begin
                due_push(RK_REPLY, ST_BAD_BLOCK, w, 1'b1);
            end
            else
            begin
                if (depth == 0)
                begin
                    stack_mem[0] = '0;
                    depth        = 1;
                end
                if (depth >= CAPACITY)
                begin
                    due_push(RK_SPILL, ST_OK, BLK_W'(CAPACITY), 1'b0);
                    for (int i = 0; i < CAPACITY; i++)
                        due_push(RK_SPILL, ST_OK, stack_mem[i], 1'b0);
                    stack_mem[0] = w;
                    depth        = 1;
                    spilled      = 1'b1;
                    due_push(RK_REPLY, ST_SPILLED, w, 1'b1);
                end
                else
                begin
                    stack_mem[depth] = w;
                    depth++;
                    due_push(RK_REPLY, ST_OK, w, 1'b1);
                end
            end
        endfunction

        function void match_result(logic rk, logic [2:0] st, logic [BLK_W-1:0] v, logic lst);
            stack_result_t e;
            if (due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: kind %0d status %0d value %0d last %0d",
                             rk, st, v, lst);
            end
            else
            begin
                e = due.pop_front();
                if (e.rkind !== rk || e.status !== st || e.value !== v || e.last !== lst)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("word mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 e.rkind, e.status, e.value, e.last, rk, st, v, lst);
                end
            end
        endfunction
    endclass

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0] paddr        = '0;
    logic [APB_DATA_W-1:0] pwdata       = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic [1:0]            kind         = KIND_ALLOC;
    logic [BLK_W-1:0]      block_number = '0;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    logic                  result_kind;
    logic [2:0]            status;
    logic [BLK_W-1:0]      value;
    logic                  last;

    free_stack_tracker sb = new();

    int send_idle = 21;
    int recv_idle = 83;
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    bit filling   = 1'b1;

    chained_free_block_stack dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .block_number (block_number),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .status       (status),
        .value        (value),
        .last         (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // receive side: check each accepted word, then pick next cycle's stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.match_result(result_kind, status, value, last);
        if (hold_req && !hold_done)
        begin
            hold_left = 300;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    initial
    begin
        #(2_000_000);
        $display("chained_free_block_stack_tb failed");
        $finish;
    end

    function automatic logic [BLK_W-1:0] pick_valid();
        int lo;
        int hi;
        int r;
        lo = int'(sb.inode_blocks) + 2;
        hi = int'(sb.volume_blocks) - 1;
        if (lo > hi)
            return BLK_W'($urandom);
        r = $urandom_range(9);
        if (r == 0)
            return BLK_W'(lo);
        if (r == 1)
            return BLK_W'(hi);
        return BLK_W'($urandom_range(hi, lo));
    endfunction

    function automatic logic [BLK_W-1:0] pick_invalid();
        int lo;
        lo = int'(sb.inode_blocks) + 2;
        if ($urandom_range(1) == 0)
            return BLK_W'($urandom_range(lo - 1, 0));
        return BLK_W'($urandom_range((1 << BLK_W) - 1, int'(sb.volume_blocks)));
    endfunction

    // mostly well-formed traffic: fill to spill, drain to refill, proper chains
    task automatic random_word(output logic [1:0] k, output logic [BLK_W-1:0] w);
        int r;
        int r2;
        r  = $urandom_range(99);
        r2 = $urandom_range(99);
        if (sb.spilled)
        begin
            sb.spilled = 1'b0;
            filling    = 1'b0;
        end
        if (sb.busy())
        begin
            if (r < 88)
            begin
                k = KIND_REFILL;
                if (sb.want_count)
                begin
                    if (r2 < 50)
                        w = BLK_W'($urandom_range(4, 0));
                    else if (r2 < 75)
                        w = BLK_W'($urandom_range(CAPACITY, 5));
                    else if (r2 < 85)
                        w = BLK_W'(CAPACITY);
                    else
                        w = BLK_W'($urandom_range((1 << BLK_W) - 1, CAPACITY + 1));
                end
                else
                begin
                    if (r2 < 80)
                        w = pick_valid();
                    else if (r2 < 88)
                        w = '0;
                    else
                        w = pick_invalid();
                end
            end
            else if (r < 95)
            begin
                k = ($urandom_range(1) == 1) ? KIND_FREE : KIND_ALLOC;
                w = BLK_W'($urandom);
            end
            else
            begin
                k = KIND_UNKNOWN;
                w = BLK_W'($urandom);
            end
        end
        else
        begin
            if (!filling && (sb.depth == 0 || $urandom_range(99) < 4))
                filling = 1'b1;
            else if (filling && $urandom_range(99) < 3)
                filling = 1'b0;
            if (r < 80)
            begin
                if ((filling ? 85 : 15) > r2)
                begin
                    k = KIND_FREE;
                    w = pick_valid();
                end
                else
                begin
                    k = KIND_ALLOC;
                    w = BLK_W'($urandom);
                end
            end
            else if (r < 88)
            begin
                k = KIND_FREE;
                w = pick_invalid();
            end
            else if (r < 93)
            begin
                k = KIND_REFILL;
                w = BLK_W'($urandom);
            end
            else if (r < 97)
            begin
                k = KIND_UNKNOWN;
                w = BLK_W'($urandom);
            end
            else
            begin
                k = KIND_ALLOC;
                w = BLK_W'($urandom);
            end
        end
    endtask

    task automatic send_word(input logic [1:0] k, input logic [BLK_W-1:0] w);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        block_number <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.take_word(k, w);
    endtask

    task automatic run_random(input int n);
        logic [1:0]       k;
        logic [BLK_W-1:0] w;
        repeat (n)
        begin
            random_word(k, w);
            send_word(k, w);
        end
        in_valid <= 1'b0;
    endtask

    // psel stays high between back-to-back writes; the caller drops it
    task automatic apb_write(input logic idx, input logic [BLK_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DATA_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_reg(idx, v);
    endtask

    task automatic configure(input logic [BLK_W-1:0] inode, input logic [BLK_W-1:0] vol);
        apb_write(REG_INODE_BLOCKS, inode);
        apb_write(REG_VOLUME_BLOCKS, vol);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_idle();
        while (sb.due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        configure(16'd10, 16'd100);

        send_word(KIND_ALLOC, 16'h0000);     // empty stack
        send_word(KIND_REFILL, 16'hFFFF);    // stray refill word
        send_word(KIND_UNKNOWN, 16'hFFFF);
        send_word(KIND_UNKNOWN, 16'h0000);
        send_word(KIND_FREE, 16'd0);
        send_word(KIND_FREE, 16'd11);        // just below the valid range
        send_word(KIND_FREE, 16'd100);       // equal to volume size
        send_word(KIND_FREE, 16'hFFFF);
        send_word(KIND_FREE, 16'd12);        // empty stack: end mark goes in first
        send_word(KIND_FREE, 16'd99);
        send_word(KIND_FREE, 16'd50);
        in_valid <= 1'b0;
        wait_idle();

        // narrow the range so that 50 and 12 get skipped on the way down
        configure(16'd50, 16'd100);
        send_word(KIND_ALLOC, 16'hFFFF);
        send_word(KIND_ALLOC, 16'h0000);     // skip 12, hit end mark
        send_word(KIND_ALLOC, 16'h5A5A);
        send_word(KIND_REFILL, 16'h0000);
        in_valid <= 1'b0;
        wait_idle();

        configure(16'd0, 16'hFFFF);
        run_random(30);
        wait_idle();

        send_idle = 83;
        recv_idle = 21;
        configure(16'd20, 16'd120);
        hold_req = 1'b1;
        run_random(30);
        wait_idle();

        // empty valid range: every free is refused, every pop is skipped
        configure(16'd65533, 16'hFFFF);
        run_random(8);
        wait_idle();

        send_idle = 0;
        recv_idle = 0;
        configure(16'd3, 16'd60);
        run_random(27);
        wait_idle();

        if (sb.errors == 0 && sb.due.size() == 0)
            $display("chained_free_block_stack_tb passed");
        else
            $display("chained_free_block_stack_tb failed");
        $finish;
    end

endmodule
